// File: design/pcsp_pkg.sv
// shared types, constants and helpers of the png chunk stream parser
package pcsp_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned WordW  = 32;
    localparam int unsigned EventW = 4;
    localparam int unsigned CodeW  = 4;
    localparam int unsigned PhaseW = 3;
    localparam int unsigned PartW  = 2;

    // parser phases
    localparam logic [PhaseW-1:0] PH_SIG  = 3'd0;
    localparam logic [PhaseW-1:0] PH_LEN  = 3'd1;
    localparam logic [PhaseW-1:0] PH_TYPE = 3'd2;
    localparam logic [PhaseW-1:0] PH_DATA = 3'd3;
    localparam logic [PhaseW-1:0] PH_CRC  = 3'd4;
    localparam logic [PhaseW-1:0] PH_APP  = 3'd5;
    localparam logic [PhaseW-1:0] PH_HALT = 3'd6;

    // text sub-parts
    localparam logic [PartW-1:0] TP_KEY    = 2'd0;
    localparam logic [PartW-1:0] TP_METHOD = 2'd1;
    localparam logic [PartW-1:0] TP_TEXT   = 2'd2;

    // chunk types, big-endian packed
    localparam logic [WordW-1:0] KIND_IEND = 32'h4945_4E44;
    localparam logic [WordW-1:0] KIND_TIME = 32'h7449_4D45;
    localparam logic [WordW-1:0] KIND_IHDR = 32'h4948_4452;
    localparam logic [WordW-1:0] KIND_TEXT = 32'h7445_5874;
    localparam logic [WordW-1:0] KIND_ZTXT = 32'h7A54_5874;

    // item kinds on the input
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // result events
    localparam logic [EventW-1:0] EV_FIELD   = 4'd0;
    localparam logic [EventW-1:0] EV_KEY     = 4'd1;
    localparam logic [EventW-1:0] EV_TEXT    = 4'd2;
    localparam logic [EventW-1:0] EV_COMP    = 4'd3;
    localparam logic [EventW-1:0] EV_METHOD  = 4'd4;
    localparam logic [EventW-1:0] EV_BADSIG  = 4'd5;
    localparam logic [EventW-1:0] EV_TEXTEND = 4'd6;
    localparam logic [EventW-1:0] EV_END     = 4'd7;
    localparam logic [EventW-1:0] EV_APP     = 4'd8;

    // field codes
    localparam logic [CodeW-1:0] FC_WIDTH    = 4'd0;
    localparam logic [CodeW-1:0] FC_HEIGHT   = 4'd1;
    localparam logic [CodeW-1:0] FC_YEAR     = 4'd7;
    localparam logic [CodeW-1:0] FC_TEXT_PLN = 4'd0;
    localparam logic [CodeW-1:0] FC_TEXT_CMP = 4'd1;

    // data byte positions
    localparam logic [WordW-1:0] POS_LEN_LAST = 32'd3;
    localparam logic [WordW-1:0] POS_SIG_LAST = 32'd7;
    localparam logic [WordW-1:0] POS_HDR_W    = 32'd3;
    localparam logic [WordW-1:0] POS_HDR_H    = 32'd7;
    localparam logic [WordW-1:0] POS_HDR_WORD = 32'd8;
    localparam logic [WordW-1:0] POS_HDR_END  = 32'd13;
    localparam logic [WordW-1:0] POS_TIM_YEAR = 32'd1;
    localparam logic [WordW-1:0] POS_TIM_WORD = 32'd2;
    localparam logic [WordW-1:0] POS_TIM_END  = 32'd7;
    localparam logic [WordW-1:0] HDR_CODE_OFS = 32'd6;
    localparam logic [WordW-1:0] TIM_CODE_OFS = 32'd6;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [WordW-1:0]  byte_count;
        logic [WordW-1:0]  chunk_size;
        logic [WordW-1:0]  chunk_kind;
        logic [WordW-1:0]  assembler;
        logic [PartW-1:0]  text_part;
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [EventW-1:0] event_res;
        logic [CodeW-1:0]  field_code;
        logic [WordW-1:0]  value;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:      PH_SIG,
        byte_count: '0,
        chunk_size: '0,
        chunk_kind: '0,
        assembler:  '0,
        text_part:  TP_KEY
    };

    function automatic logic [ByteW-1:0] sig_byte(input logic [2:0] idx);
        logic [ByteW-1:0] b;
        unique case (idx)
            3'd0: b = 8'h89;
            3'd1: b = 8'h50;
            3'd2: b = 8'h4E;
            3'd3: b = 8'h47;
            3'd4: b = 8'h0D;
            3'd5: b = 8'h0A;
            3'd6: b = 8'h1A;
            3'd7: b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: design/pcsp_if.sv
// valid/ready channel interfaces for input and result items
interface pcsp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source(output valid, output kind, output data_byte, input ready);
    modport sink(input valid, input kind, input data_byte, output ready);
endinterface

interface pcsp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [3:0]  field_code;
    logic [31:0] value;

    modport source(output valid, output event_res, output field_code, output value,
                   input ready);
    modport sink(input valid, input event_res, input field_code, input value,
                 output ready);
endinterface

// File: design/png_chunk_stream_parser.sv
// png chunk stream parser top level
// Takes one file byte per item and can accept an item every cycle: each byte
// updates the parser state registers in the cycle it is accepted, and its
// result, if any, is held in a result register that drives the output. Input
// ready stays high while that register is empty or being taken, so a full
// output stalls the input only when the sink stalls. A restart item returns
// the parser to the signature check and gives no result; after a bad
// signature only a restart is acted on.
module png_chunk_stream_parser
    import pcsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    pcsp_in_if.sink           i_in,
    pcsp_out_if.source        o_out
);

    t_state           r_state;
    t_state           n_state;
    t_result          w_res;
    logic             r_out_valid;
    logic [EventW-1:0] r_event_res;
    logic [CodeW-1:0] r_field_code;
    logic [WordW-1:0] r_value;
    logic             w_in_acc;

    pcsp_step u_step (
        .i_state     (r_state),
        .i_kind      (i_in.kind),
        .i_data_byte (i_in.data_byte),
        .o_state     (n_state),
        .o_res       (w_res)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_acc   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_state     <= n_state;
                r_out_valid <= w_res.valid;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_res.valid) begin
            r_event_res  <= w_res.event_res;
            r_field_code <= w_res.field_code;
            r_value      <= w_res.value;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_res  = r_event_res;
    assign o_out.field_code = r_field_code;
    assign o_out.value      = r_value;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_state.phase == PH_HALT && i_in.kind == KIND_BYTE)
        |=> r_state.phase == PH_HALT)
        else $error("parser left halt without a restart");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_HALT) |-> !w_res.valid)
        else $error("result produced while halted");

    a_sig_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_SIG) |-> (r_state.byte_count <= POS_SIG_LAST))
        else $error("signature position out of range");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.kind == KIND_RESTART)
        |=> (r_state.phase == PH_SIG && r_state.byte_count == '0 && !r_out_valid))
        else $error("restart did not return to signature check");

endmodule

// File: design/pcsp_step.sv
// next parser state and optional result for one input item
module pcsp_step
    import pcsp_pkg::*;
(
    input  t_state           i_state,
    input  logic             i_kind,
    input  logic [ByteW-1:0] i_data_byte,
    output t_state           o_state,
    output t_result          o_res
);

    logic [WordW-1:0] w_b;
    logic [WordW-1:0] w_shift;
    logic [WordW-1:0] w_count_inc;
    logic             w_is_text;
    logic             w_is_ztxt;

    assign w_b         = {{(WordW-ByteW){1'b0}}, i_data_byte};
    assign w_shift     = {i_state.assembler[WordW-ByteW-1:0], i_data_byte};
    assign w_count_inc = i_state.byte_count + 32'd1;
    assign w_is_ztxt   = (i_state.chunk_kind == KIND_ZTXT);
    assign w_is_text   = (i_state.chunk_kind == KIND_TEXT) || w_is_ztxt;

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        if (i_kind == KIND_RESTART) begin
            o_state = STATE_RESET;
        end else begin
            unique case (i_state.phase)
                PH_SIG: begin
                    if (i_data_byte != sig_byte(i_state.byte_count[2:0])) begin
                        o_state.phase = PH_HALT;
                        o_res = '{valid: 1'b1, event_res: EV_BADSIG, field_code: '0,
                                  value: w_b};
                    end else if (i_state.byte_count >= POS_SIG_LAST) begin
                        o_state.byte_count = '0;
                        o_state.assembler  = '0;
                        o_state.phase      = PH_LEN;
                    end else begin
                        o_state.byte_count = w_count_inc;
                    end
                end
                PH_LEN: begin
                    o_state.assembler = w_shift;
                    if (i_state.byte_count >= POS_LEN_LAST) begin
                        o_state.chunk_size = w_shift;
                        o_state.assembler  = '0;
                        o_state.byte_count = '0;
                        o_state.phase      = PH_TYPE;
                    end else begin
                        o_state.byte_count = w_count_inc;
                    end
                end
                PH_TYPE: begin
                    o_state.assembler = w_shift;
                    if (i_state.byte_count >= POS_LEN_LAST) begin
                        o_state.chunk_kind = w_shift;
                        o_state.byte_count = '0;
                        o_state.assembler  = '0;
                        o_state.text_part  = TP_KEY;
                        o_state.phase = (i_state.chunk_size == '0) ? PH_CRC : PH_DATA;
                    end else begin
                        o_state.byte_count = w_count_inc;
                    end
                end
                PH_DATA: begin
                    if (i_state.chunk_kind == KIND_IHDR) begin
                        if (i_state.byte_count < POS_HDR_WORD) begin
                            o_state.assembler = w_shift;
                            if (i_state.byte_count == POS_HDR_W) begin
                                o_res = '{valid: 1'b1, event_res: EV_FIELD,
                                          field_code: FC_WIDTH, value: w_shift};
                            end else if (i_state.byte_count == POS_HDR_H) begin
                                o_res = '{valid: 1'b1, event_res: EV_FIELD,
                                          field_code: FC_HEIGHT, value: w_shift};
                            end
                        end else if (i_state.byte_count < POS_HDR_END) begin
                            o_res.valid      = 1'b1;
                            o_res.event_res  = EV_FIELD;
                            o_res.field_code = CodeW'(i_state.byte_count - HDR_CODE_OFS);
                            o_res.value      = w_b;
                        end
                    end else if (i_state.chunk_kind == KIND_TIME) begin
                        if (i_state.byte_count < POS_TIM_WORD) begin
                            o_state.assembler = w_shift;
                            if (i_state.byte_count == POS_TIM_YEAR) begin
                                o_res = '{valid: 1'b1, event_res: EV_FIELD,
                                          field_code: FC_YEAR,
                                          value: {16'd0, w_shift[15:0]}};
                            end
                        end else if (i_state.byte_count < POS_TIM_END) begin
                            o_res.valid      = 1'b1;
                            o_res.event_res  = EV_FIELD;
                            o_res.field_code = CodeW'(i_state.byte_count + TIM_CODE_OFS);
                            o_res.value      = w_b;
                        end
                    end else if (w_is_text) begin
                        priority case (i_state.text_part)
                            TP_KEY: begin
                                if (i_data_byte == '0) begin
                                    o_state.text_part = w_is_ztxt ? TP_METHOD : TP_TEXT;
                                end else begin
                                    o_res = '{valid: 1'b1, event_res: EV_KEY,
                                              field_code: '0, value: w_b};
                                end
                            end
                            TP_METHOD: begin
                                o_state.text_part = TP_TEXT;
                                if (i_data_byte != '0) begin
                                    o_res = '{valid: 1'b1, event_res: EV_METHOD,
                                              field_code: '0, value: w_b};
                                end
                            end
                            default: begin
                                o_res = '{valid: 1'b1,
                                          event_res: w_is_ztxt ? EV_COMP : EV_TEXT,
                                          field_code: '0, value: w_b};
                            end
                        endcase
                    end
                    if (w_count_inc == i_state.chunk_size) begin
                        o_state.byte_count = '0;
                        o_state.phase      = PH_CRC;
                    end else begin
                        o_state.byte_count = w_count_inc;
                    end
                end
                PH_CRC: begin
                    if (i_state.byte_count == '0 && w_is_text) begin
                        o_res = '{valid: 1'b1, event_res: EV_TEXTEND,
                                  field_code: w_is_ztxt ? FC_TEXT_CMP : FC_TEXT_PLN,
                                  value: '0};
                    end
                    if (i_state.byte_count >= POS_LEN_LAST) begin
                        o_state.byte_count = '0;
                        o_state.assembler  = '0;
                        if (i_state.chunk_kind == KIND_IEND) begin
                            o_state.phase = PH_APP;
                            o_res = '{valid: 1'b1, event_res: EV_END, field_code: '0,
                                      value: '0};
                        end else begin
                            o_state.phase = PH_LEN;
                        end
                    end else begin
                        o_state.byte_count = w_count_inc;
                    end
                end
                PH_APP: begin
                    o_res = '{valid: 1'b1, event_res: EV_APP, field_code: '0, value: w_b};
                end
                default: begin
                end
            endcase
        end
    end

endmodule
